### sv/bgab_pkg.sv
// bgab_pkg: types and constants shared by the baro/gps altitude bias calibration block
// no dependencies; used by every module under sv/
`default_nettype none

package bgab_pkg;

    // fixed field widths
    localparam int ALT_W  = 27;
    localparam int BIAS_W = 27;
    localparam int COR_W  = 28;
    localparam int CNT_W  = 16;
    localparam int TIME_W = 32;

    // saturation limits
    localparam int BIAS_MAX_I = 2**26 - 1;
    localparam int BIAS_MIN_I = -(2**26);
    localparam int COR_MAX_I  = 2**27 - 1;
    localparam int COR_MIN_I  = -(2**27);

    // pair count saturates here
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // configuration register reset values
    localparam logic [CNT_W-1:0]  TARGET_RST  = 16'd50;
    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd10000;

    // register index, taken from paddr[2]
    localparam logic REG_SAMPLE_TARGET = 1'b0;
    localparam logic REG_TIMEOUT_MS    = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GPS_GO,
        ST_GPS_WAIT,
        ST_BARO_GO,
        ST_BARO_WAIT,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_baro;
        logic cap_gm;
        logic cap_bm;
        logic finish;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fin_req;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

### sv/bgab_div.sv
// bgab_div: serial restoring divider, signed dividend by unsigned 16 bit divisor
// one quotient bit per cycle, truncating toward zero; uses bgab_pkg
`default_nettype none

module bgab_div #(
    parameter int W = 48
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic signed [W-1:0]           dividend,
    input  wire logic [bgab_pkg::CNT_W-1:0]    divisor,
    output logic                               done,
    output logic signed [W-1:0]                quotient
);

    localparam int CW = $clog2(W + 1);
    localparam int DW = bgab_pkg::CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic          neg_reg, neg_next;
    logic [DW:0]   trial;
    logic          ge;

    // one restoring step per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[W-1]};
        ge        = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            quo_next  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            rem_next  = '0;
            div_next  = divisor;
            neg_next  = dividend[W-1];
        end else if (busy_reg) begin
            quo_next = {quo_reg[W-2:0], ge};
            rem_next = ge ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // sign restore
    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~quo_reg + W'(1)) : $signed(quo_reg);

endmodule

`default_nettype wire

### sv/bgab_datapath.sv
// bgab_datapath: calibration state, accumulators, bias and result registers
// depends on bgab_pkg and bgab_div
`default_nettype none

module bgab_datapath #(
    parameter int SUM_WIDTH = 48
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire bgab_pkg::cmd_t                       cmd,
    output bgab_pkg::status_t                         status,
    input  wire logic                                 s_gps_ok,
    input  wire logic signed [bgab_pkg::ALT_W-1:0]    s_gps_alt_mm,
    input  wire logic                                 s_baro_ok,
    input  wire logic signed [bgab_pkg::ALT_W-1:0]    s_baro_alt_mm,
    input  wire logic [bgab_pkg::TIME_W-1:0]          s_time_ms,
    input  wire logic                                 s_restart,
    input  wire logic [bgab_pkg::CNT_W-1:0]           sample_target,
    input  wire logic [bgab_pkg::TIME_W-1:0]          timeout_ms,
    output logic signed [bgab_pkg::COR_W-1:0]         m_corrected_alt_mm,
    output logic signed [bgab_pkg::BIAS_W-1:0]        m_bias_mm,
    output logic                                      m_bias_ready,
    output logic                                      m_cal_done
);

    localparam int W  = SUM_WIDTH;
    localparam int AW = bgab_pkg::ALT_W;
    localparam int BW = bgab_pkg::BIAS_W;
    localparam int RW = bgab_pkg::COR_W;
    localparam int NW = bgab_pkg::CNT_W;
    localparam int TW = bgab_pkg::TIME_W;

    localparam logic signed [W:0]    BIAS_MAX_X = (W+1)'(bgab_pkg::BIAS_MAX_I);
    localparam logic signed [W:0]    BIAS_MIN_X = (W+1)'(bgab_pkg::BIAS_MIN_I);
    localparam logic signed [W-1:0]  COR_MAX_X  = W'(bgab_pkg::COR_MAX_I);
    localparam logic signed [W-1:0]  COR_MIN_X  = W'(bgab_pkg::COR_MIN_I);

    // control flags
    logic started_reg, done_reg, bok_reg;
    // calibration payload
    logic [NW-1:0]        cnt_reg;
    logic [TW-1:0]        start_reg;
    logic [W-1:0]         gsum_reg, bsum_reg;
    logic signed [BW-1:0] bias_reg;
    logic signed [RW-1:0] corr_reg;
    logic signed [W-1:0]  gm_reg, bm_reg;

    // request view of the state, after the first-item clear
    logic                 clr, done0, bok0, pair, acc;
    logic [NW-1:0]        cnt0, cnt_inc;
    logic [TW-1:0]        start0, elapsed;
    logic [W-1:0]         gsum0, bsum0, gsum_acc, bsum_acc;
    logic signed [BW-1:0] bias0;
    logic signed [RW-1:0] corr0, corr_new;

    // completion values
    logic signed [W:0]    diff;
    logic signed [BW-1:0] bias_sat;
    logic signed [RW-1:0] cor_sat;

    logic                 div_done;
    logic signed [W-1:0]  div_q;

    // accept path: clear on first request, correct, accumulate, test completion
    always_comb begin
        clr      = !started_reg;
        done0    = clr ? 1'b0 : done_reg;
        bok0     = clr ? 1'b0 : bok_reg;
        cnt0     = clr ? '0 : cnt_reg;
        start0   = clr ? s_time_ms : start_reg;
        gsum0    = clr ? '0 : gsum_reg;
        bsum0    = clr ? '0 : bsum_reg;
        bias0    = clr ? '0 : bias_reg;
        corr0    = clr ? '0 : corr_reg;
        pair     = s_gps_ok && s_baro_ok;
        acc      = !done0 && pair;
        gsum_acc = gsum0 + {{(W-AW){s_gps_alt_mm[AW-1]}}, s_gps_alt_mm};
        bsum_acc = bsum0 + {{(W-AW){s_baro_alt_mm[AW-1]}}, s_baro_alt_mm};
        cnt_inc  = (acc && cnt0 != bgab_pkg::CNT_MAX) ? cnt0 + NW'(1) : cnt0;
        elapsed  = s_time_ms - start0;
        corr_new = s_baro_ok ? ($signed({s_baro_alt_mm[AW-1], s_baro_alt_mm})
                               + $signed({bias0[BW-1], bias0})) : corr0;
        status.fin_req = !s_restart && !done0 && (cnt_inc != '0)
                         && ((cnt_inc >= sample_target) || (elapsed >= timeout_ms));
        status.div_done = div_done;
    end

    // bias = gps mean - baro mean, both saturated
    always_comb begin
        diff = $signed({gm_reg[W-1], gm_reg}) - $signed({bm_reg[W-1], bm_reg});
        if (diff > BIAS_MAX_X) begin
            bias_sat = BW'(bgab_pkg::BIAS_MAX_I);
        end else if (diff < BIAS_MIN_X) begin
            bias_sat = BW'(bgab_pkg::BIAS_MIN_I);
        end else begin
            bias_sat = diff[BW-1:0];
        end
        if (gm_reg > COR_MAX_X) begin
            cor_sat = RW'(bgab_pkg::COR_MAX_I);
        end else if (gm_reg < COR_MIN_X) begin
            cor_sat = RW'(bgab_pkg::COR_MIN_I);
        end else begin
            cor_sat = gm_reg[RW-1:0];
        end
    end

    // shared mean divider
    bgab_div #(
        .W(W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_baro ? $signed(bsum_reg) : $signed(gsum_reg)),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            bok_reg     <= 1'b0;
        end else if (cmd.accept) begin
            started_reg <= 1'b1;
            done_reg    <= s_restart ? 1'b0 : done0;
            bok_reg     <= s_restart ? 1'b0 : bok0;
        end else if (cmd.finish) begin
            done_reg    <= 1'b1;
            bok_reg     <= 1'b1;
        end
    end

    // calibration payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (s_restart) begin
                cnt_reg   <= '0;
                start_reg <= s_time_ms;
                gsum_reg  <= '0;
                bsum_reg  <= '0;
                bias_reg  <= '0;
                corr_reg  <= '0;
            end else begin
                cnt_reg   <= cnt_inc;
                start_reg <= start0;
                gsum_reg  <= acc ? gsum_acc : gsum0;
                bsum_reg  <= acc ? bsum_acc : bsum0;
                bias_reg  <= bias0;
                corr_reg  <= corr_new;
            end
        end else if (cmd.finish) begin
            bias_reg <= bias_sat;
            corr_reg <= cor_sat;
        end
        if (cmd.cap_gm) begin
            gm_reg <= div_q;
        end
        if (cmd.cap_bm) begin
            bm_reg <= div_q;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_corrected_alt_mm <= corr_reg;
            m_bias_mm          <= bias_reg;
            m_bias_ready       <= bok_reg;
            m_cal_done         <= done_reg;
        end
    end

endmodule

`default_nettype wire

### sv/bgab_ctrl.sv
// bgab_ctrl: sequencing state machine and result valid for the calibration block
// depends on bgab_pkg; drives bgab_datapath through cmd_t, reads status_t
`default_nettype none

module bgab_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bgab_pkg::cmd_t           cmd,
    input  wire bgab_pkg::status_t   status
);

    bgab_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bgab_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == bgab_pkg::ST_IDLE);
        out_free   = !m_valid_reg || m_ready;
        case (state_reg)
            bgab_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.fin_req ? bgab_pkg::ST_GPS_GO : bgab_pkg::ST_OUT;
                end
            end
            bgab_pkg::ST_GPS_GO: begin
                cmd.div_start = 1'b1;
                state_next    = bgab_pkg::ST_GPS_WAIT;
            end
            bgab_pkg::ST_GPS_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_gm = 1'b1;
                    state_next = bgab_pkg::ST_BARO_GO;
                end
            end
            bgab_pkg::ST_BARO_GO: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_baro = 1'b1;
                state_next       = bgab_pkg::ST_BARO_WAIT;
            end
            bgab_pkg::ST_BARO_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_bm = 1'b1;
                    state_next = bgab_pkg::ST_FINISH;
                end
            end
            bgab_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = bgab_pkg::ST_OUT;
            end
            bgab_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = bgab_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bgab_pkg::ST_IDLE;
            end
        endcase
        m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### sv/baro_gps_altitude_bias_cal_unit.sv
// baro_gps_altitude_bias_cal_unit: top level, configuration registers and APB port
// depends on bgab_pkg, bgab_ctrl, bgab_datapath (which holds bgab_div)
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid/s_ready    gps_ok, gps_alt_mm, baro_ok, baro_alt_mm,
//                                          time_ms, restart
//  m_*       out        m_valid/m_ready    corrected_alt_mm, bias_mm, bias_ready, cal_done
//  apb       in/out     psel/penable       sample_target (0x0), timeout_ms (0x4)
//
// a request that does not complete calibration goes through accept, then result load
// a completing request computes two means in turn from one serial
// divider that retires one quotient bit a cycle, then the bias step
// the next request is accepted while the result register still waits on m_ready
// aresetn is synchronous; configuration returns to target 50, timeout 10000 ms
`default_nettype none

module baro_gps_altitude_bias_cal_unit #(
    parameter int SUM_WIDTH = 48
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_gps_ok,
    input  wire logic signed [bgab_pkg::ALT_W-1:0]    s_gps_alt_mm,
    input  wire logic                                 s_baro_ok,
    input  wire logic signed [bgab_pkg::ALT_W-1:0]    s_baro_alt_mm,
    input  wire logic [bgab_pkg::TIME_W-1:0]          s_time_ms,
    input  wire logic                                 s_restart,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [bgab_pkg::COR_W-1:0]         m_corrected_alt_mm,
    output logic signed [bgab_pkg::BIAS_W-1:0]        m_bias_mm,
    output logic                                      m_bias_ready,
    output logic                                      m_cal_done,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [bgab_pkg::CNT_W-1:0]  target_reg;
    logic [bgab_pkg::TIME_W-1:0] timeout_reg;
    logic                        wr_en;
    bgab_pkg::cmd_t              cmd;
    bgab_pkg::status_t           status;

    // configuration writes
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= bgab_pkg::TARGET_RST;
            timeout_reg <= bgab_pkg::TIMEOUT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                bgab_pkg::REG_SAMPLE_TARGET: target_reg  <= pwdata[bgab_pkg::CNT_W-1:0];
                bgab_pkg::REG_TIMEOUT_MS:    timeout_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            bgab_pkg::REG_SAMPLE_TARGET: prdata = {16'h0000, target_reg};
            bgab_pkg::REG_TIMEOUT_MS:    prdata = timeout_reg;
            default:                     prdata = '0;
        endcase
    end

    bgab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    bgab_datapath #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_gps_ok           (s_gps_ok),
        .s_gps_alt_mm       (s_gps_alt_mm),
        .s_baro_ok          (s_baro_ok),
        .s_baro_alt_mm      (s_baro_alt_mm),
        .s_time_ms          (s_time_ms),
        .s_restart          (s_restart),
        .sample_target      (target_reg),
        .timeout_ms         (timeout_reg),
        .m_corrected_alt_mm (m_corrected_alt_mm),
        .m_bias_mm          (m_bias_mm),
        .m_bias_ready       (m_bias_ready),
        .m_cal_done         (m_cal_done)
    );

endmodule

`default_nettype wire

### sv/bgab_checker.sv
// bgab_checker: port-level assertions for baro_gps_altitude_bias_cal_unit
// depends on bgab_pkg; bound to the top level at the end of this file
`default_nettype none

module bgab_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic signed [bgab_pkg::COR_W-1:0]    m_corrected_alt_mm,
    input wire logic signed [bgab_pkg::BIAS_W-1:0]   m_bias_mm,
    input wire logic                                 m_bias_ready,
    input wire logic                                 m_cal_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corrected_alt_mm)
            && $stable(m_bias_mm) && $stable(m_cal_done))
        else $error("result changed while stalled");

    // bias and completion flags are set and cleared together
    a_flags_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bias_ready == m_cal_done)
        else $error("bias_ready and cal_done disagree");

    // bias reads zero before calibration
    a_bias_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_cal_done |-> m_bias_mm == '0)
        else $error("nonzero bias before calibration");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on back-to-back cycles");

endmodule

bind baro_gps_altitude_bias_cal_unit bgab_checker u_bgab_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_corrected_alt_mm (m_corrected_alt_mm),
    .m_bias_mm          (m_bias_mm),
    .m_bias_ready       (m_bias_ready),
    .m_cal_done         (m_cal_done)
);

`default_nettype wire
